>>> src/vpr_pkg.sv
// shared types and constants for the vector projection and rejection core
`timescale 1ns / 1ps
package vpr_pkg;

   localparam int LANES      = 3;
   localparam int COMP_W     = 32;
   localparam int DIV_STEPS  = 32;
   localparam int NUM_W      = 95;
   localparam int LANE_DEPTH = DIV_STEPS + 4;
   localparam int PIPE_DEPTH = LANE_DEPTH + 2;

   localparam logic [COMP_W-1:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [COMP_W-1:0] SAT_MIN = 32'h8000_0000;

   // operation select carried in req tuser
   localparam logic FUNC_PROJ = 1'b0;
   localparam logic FUNC_REJ  = 1'b1;

   // tuser bit positions of a result beat
   localparam int USER_ZERO_DIR  = 0;
   localparam int USER_SATURATED = 1;

   typedef struct packed {
      logic signed [63:0] prod;
      logic [63:0]        sq;
      logic signed [31:0] a;
      logic [31:0]        mag;
      logic               bneg;
   } mul_type;

   typedef struct packed {
      logic [63:0] dmag;
      logic        dneg;
      logic [63:0] msq;
      logic        zero;
   } mrg_type;

   typedef struct packed {
      logic [31:0]        mag;
      logic               bneg;
      logic signed [31:0] a;
      logic               func;
      mrg_type            mrg;
   } lane_in_type;

   typedef struct packed {
      logic [63:0]        m;
      logic               sign;
      logic signed [31:0] a;
      logic               func;
      logic               zero;
   } side_type;

   typedef struct packed {
      logic [31:0] r;
      logic        sat;
      logic        zero;
   } lane_out_type;

endpackage

>>> src/vpr_mul_lane.sv
// per-component multiply lane: a*b and b*b
`timescale 1ns / 1ps
module vpr_mul_lane import vpr_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output mul_type            mul
);

   mul_type     mul_ff;
   mul_type     mul_in;
   logic signed [63:0] bb;

   always_comb begin
      bb          = b * b;
      mul_in.prod = a * b;
      mul_in.sq   = bb;
      mul_in.a    = a;
      mul_in.mag  = b[31] ? (~b + 32'sd1) : b;
      mul_in.bneg = b[31];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_ff <= mul_in;
      end
   end

   assign mul = mul_ff;

endmodule

>>> src/vpr_merge.sv
// merging stage: sums the lane products into a.b and b.b
`timescale 1ns / 1ps
module vpr_merge import vpr_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  mul_type mul [LANES],
   output mrg_type mrg
);

   mrg_type            mrg_ff;
   mrg_type            mrg_in;
   logic signed [65:0] dot;
   logic [65:0]        dot_neg;
   logic [63:0]        msq;

   always_comb begin
      dot = 66'sd0;
      msq = 64'd0;
      for (int i = 0; i < LANES; i++) begin
         dot = dot + {{2{mul[i].prod[63]}}, mul[i].prod};
         msq = msq + mul[i].sq;
      end
      dot_neg     = -dot;
      mrg_in.dneg = dot[65];
      mrg_in.dmag = dot[65] ? dot_neg[63:0] : dot[63:0];
      mrg_in.msq  = msq;
      mrg_in.zero = (msq == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mrg_ff <= mrg_in;
      end
   end

   assign mrg = mrg_ff;

endmodule

>>> src/vpr_div_lane.sv
// per-component scale, pipelined divide, round, rejection subtract and saturate
`timescale 1ns / 1ps
module vpr_div_lane import vpr_pkg::*; (
   input  logic                  clock,
   input  logic [LANE_DEPTH-1:0] adv,
   input  lane_in_type           lin,
   output lane_out_type          lout
);

   logic [63:0]          pp_lo_ff, pp_hi_ff;
   side_type             side_ff [DIV_STEPS+2];
   logic [NUM_W-1:0]     rem_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff    [DIV_STEPS+1];
   logic [95:0]          num;

   // partial products of |b_i| by |a.b|
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pp_lo_ff   <= lin.mag * lin.mrg.dmag[31:0];
         pp_hi_ff   <= lin.mag * lin.mrg.dmag[63:32];
         side_ff[0] <= '{m: lin.mrg.msq, sign: lin.bneg ^ lin.mrg.dneg, a: lin.a,
                         func: lin.func, zero: lin.mrg.zero};
      end
   end

   assign num = {32'd0, pp_lo_ff} + {pp_hi_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         rem_ff[0]  <= num[NUM_W-1:0];
         q_ff[0]    <= '0;
         side_ff[1] <= side_ff[0];
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      localparam int SH = DIV_STEPS - k;
      logic [NUM_W-1:0] sh;
      logic             take;
      assign sh   = NUM_W'(side_ff[k].m) << SH;
      assign take = rem_ff[k-1] >= sh;
      always_ff @(posedge clock) begin
         if (adv[k+1]) begin
            rem_ff[k]    <= take ? rem_ff[k-1] - sh : rem_ff[k-1];
            q_ff[k]      <= {q_ff[k-1][DIV_STEPS-2:0], take};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // round half away from zero, apply sign
   logic signed [33:0] p_ff;
   logic signed [31:0] a_ff;
   logic               func_ff, zero_ff;
   logic [63:0]        rlow;
   logic               rnd;
   logic [32:0]        qr;
   logic [33:0]        qpos;

   always_comb begin
      rlow = rem_ff[DIV_STEPS][63:0];
      rnd  = {rlow, 1'b0} >= {1'b0, side_ff[DIV_STEPS+1].m};
      qr   = {1'b0, q_ff[DIV_STEPS]} + {32'd0, rnd};
      qpos = {1'b0, qr};
   end

   always_ff @(posedge clock) begin
      if (adv[DIV_STEPS+2]) begin
         p_ff    <= side_ff[DIV_STEPS+1].sign ? -qpos : qpos;
         a_ff    <= side_ff[DIV_STEPS+1].a;
         func_ff <= side_ff[DIV_STEPS+1].func;
         zero_ff <= side_ff[DIV_STEPS+1].zero;
      end
   end

   // rejection subtract and clamp
   lane_out_type       out_ff, out_in;
   logic signed [34:0] v;
   logic               hi, lo;

   always_comb begin
      v  = (func_ff == FUNC_REJ) ? ({{3{a_ff[31]}}, a_ff} - {p_ff[33], p_ff})
                                 : {p_ff[33], p_ff};
      hi = !v[34] && (|v[33:31]);
      lo = v[34] && !(&v[33:31]);
      out_in.zero = zero_ff;
      out_in.sat  = !zero_ff && (hi || lo);
      if (zero_ff) begin
         out_in.r = '0;
      end else if (hi) begin
         out_in.r = SAT_MAX;
      end else if (lo) begin
         out_in.r = SAT_MIN;
      end else begin
         out_in.r = v[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[DIV_STEPS+3]) begin
         out_ff <= out_in;
      end
   end

   assign lout = out_ff;

endmodule

>>> src/vector_projection_rejection_core.sv
// top level of the vector projection and rejection core
`timescale 1ns / 1ps
// usage
//   req beat: tdata = {bz, by, bx, az, ay, ax}, 32 bits each, signed q16.16,
//   ax in the lowest bits; tuser = func (0 projection of a onto b, 1 rejection)
//   rsp beat: tdata = {rz, ry, rx}, rx lowest; tuser bit 0 zero_dir,
//   bit 1 saturated
//   one result beat per request beat, in order
// stages
//   an accepted req beat passes through multiply, merge, two scale stages,
//   32 divide stages, round and clamp before it becomes its rsp beat
// throughput
//   one beat per cycle while not stalled; every stage, including each of the
//   32 divide stages, is a separate register, so a new beat can enter each cycle
// reset
//   synchronous, active high; clears every stage valid, so rsp_tvalid drops
// stall
//   when rsp_tready is low the pipeline keeps filling its empty stages and
//   req_tready stays high until every stage holds a beat
module vector_projection_rejection_core import vpr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // ax, ay, az, bx, by, bz
   input  logic [0:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // rx, ry, rz
   output logic [1:0]   rsp_tuser    // zero_dir, saturated
);

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic [PIPE_DEPTH-1:0] ready;
   logic [PIPE_DEPTH-1:0] adv;
   logic [PIPE_DEPTH-1:0] feed;

   // valid offered to each stage by the one before it
   assign feed = {valid_ff[PIPE_DEPTH-2:0], req_tvalid};

   // a stage may load when rsp_tready is high or when it or any stage after it has a bubble
   for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_ctl
      assign ready[k]    = rsp_tready || !(&valid_ff[PIPE_DEPTH-1:k]);
      assign adv[k]      = ready[k] && feed[k];
      assign valid_in[k] = ready[k] ? feed[k] : valid_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready[0];

   // multiply lanes
   mul_type mul [LANES];
   for (genvar i = 0; i < LANES; i++) begin : g_mul
      vpr_mul_lane u_mul (
         .clock (clock),
         .en    (adv[0]),
         .a     (req_tdata[32*i +: 32]),
         .b     (req_tdata[96 + 32*i +: 32]),
         .mul   (mul[i])
      );
   end

   logic func0_ff;
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         func0_ff <= req_tuser[0];
      end
   end

   // dot products
   mrg_type mrg;
   vpr_merge u_merge (
      .clock (clock),
      .en    (adv[1]),
      .mul   (mul),
      .mrg   (mrg)
   );

   // per lane operands held beside the merge stage
   logic               func1_ff;
   logic signed [31:0] a1_ff    [LANES];
   logic [31:0]        mag1_ff  [LANES];
   logic               bneg1_ff [LANES];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         func1_ff <= func0_ff;
         for (int i = 0; i < LANES; i++) begin
            a1_ff[i]    <= mul[i].a;
            mag1_ff[i]  <= mul[i].mag;
            bneg1_ff[i] <= mul[i].bneg;
         end
      end
   end

   // divide lanes
   lane_out_type lout [LANES];
   for (genvar i = 0; i < LANES; i++) begin : g_div
      lane_in_type lin;
      assign lin = '{mag: mag1_ff[i], bneg: bneg1_ff[i], a: a1_ff[i],
                     func: func1_ff, mrg: mrg};
      vpr_div_lane u_div (
         .clock (clock),
         .adv   (adv[PIPE_DEPTH-1:2]),
         .lin   (lin),
         .lout  (lout[i])
      );
   end

   // output beat: valid, lane results and merged lane flags
   assign rsp_tvalid                = valid_ff[PIPE_DEPTH-1];
   assign rsp_tdata                 = {lout[2].r, lout[1].r, lout[0].r};
   assign rsp_tuser[USER_ZERO_DIR]  = lout[0].zero;
   assign rsp_tuser[USER_SATURATED] = lout[0].sat || lout[1].sat || lout[2].sat;

`ifndef NO_ASSERTIONS
   // a zero direction gives a zero vector
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_ZERO_DIR] |-> rsp_tdata == 96'd0)
      else $error("zero direction with nonzero result");

   // a zero direction never clamps
   a_zero_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[USER_ZERO_DIR] && rsp_tuser[USER_SATURATED]))
      else $error("zero direction flagged as saturated");

   // a clamped beat carries at least one limit value
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_SATURATED] |->
         (lout[0].r == SAT_MAX || lout[0].r == SAT_MIN ||
          lout[1].r == SAT_MAX || lout[1].r == SAT_MIN ||
          lout[2].r == SAT_MAX || lout[2].r == SAT_MIN))
      else $error("saturated flag without a clamped component");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

>>> dv/testbench.sv
// testbench for the vector projection and rejection core: random stalls, self-checking
`timescale 1ns / 1ps
module testbench import vpr_pkg::*; ();

   typedef struct packed {
      logic [31:0] rx;
      logic [31:0] ry;
      logic [31:0] rz;
      logic        zero_dir;
      logic        saturated;
   } vec_result_type;

   localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] QMIN = 32'sh8000_0000;
   localparam logic signed [31:0] QONE = 32'sh0001_0000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;    // ax, ay, az, bx, by, bz
   logic [0:0]   req_tuser;    // func
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;    // rx, ry, rz
   logic [1:0]   rsp_tuser;    // zero_dir, saturated

   vec_result_type pending_results[$];
   int             mismatch_count = 0;
   int             hold_cycles = 0;   // long receiver hold-off, requested by a test
   bit             no_gaps = 0;       // sender and receiver run without idling
   bit             all_done = 0;

   vector_projection_rejection_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // b * (a.b) / (b.b), or a minus that for rejection, each lane rounded half away from zero, then saturated
   function automatic vec_result_type project_vec(input logic func, input logic [95:0] av,
                                                  input logic [95:0] bv);
      logic signed [67:0]  dot;
      logic [67:0]         msq;
      logic [67:0]         dmag;
      logic                dneg;
      logic [127:0]        num;
      logic [127:0]        quo;
      logic [127:0]        rem;
      logic signed [131:0] p;
      logic signed [131:0] v;
      logic signed [31:0]  ai;
      logic signed [31:0]  bi;
      logic [31:0]         bm;
      logic [31:0]         lane[3];
      vec_result_type      r;
      dot = 0;
      msq = 0;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         ai = av[32*i +: 32];
         bi = bv[32*i +: 32];
         dot += 68'(ai) * 68'(bi);
         bm = bi[31] ? -bi : bi;
         msq += 68'(bm) * 68'(bm);
      end
      if (msq == 0) begin
         r.zero_dir = 1'b1;
         return r;
      end
      dneg = dot < 0;
      dmag = dneg ? -dot : dot;
      for (int i = 0; i < 3; i++) begin
         ai = av[32*i +: 32];
         bi = bv[32*i +: 32];
         bm = bi[31] ? -bi : bi;
         num = 128'(bm) * 128'(dmag);
         quo = num / 128'(msq);
         rem = num % 128'(msq);
         if (2 * rem >= 128'(msq)) quo++;
         p = quo;
         if (bi[31] != dneg) p = -p;
         v = (func == FUNC_REJ) ? 132'(ai) - p : p;
         if (v > 132'(QMAX)) begin
            v = 132'(QMAX);
            r.saturated = 1'b1;
         end else if (v < 132'(QMIN)) begin
            v = 132'(QMIN);
            r.saturated = 1'b1;
         end
         lane[i] = v[31:0];
      end
      r.rx = lane[0];
      r.ry = lane[1];
      r.rz = lane[2];
      return r;
   endfunction

   // one request beat; valid stays high when the next beat follows without a gap
   task automatic send_vec(input logic func, input logic [95:0] av, input logic [95:0] bv);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {bv, av};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(project_vec(func, av, bv));
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? QMAX : QMIN;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 20)) - 10) * QONE;
         4: return 32'($signed($urandom_range(0, 2000)) - 1000) * 97;
         default: return 32'($signed($urandom_range(0, 131072)) - 65536) <<< 8;
      endcase
   endfunction

   function automatic logic [95:0] rand_vec();
      logic [95:0] v;
      for (int i = 0; i < 3; i++) v[32*i +: 32] = rand_comp();
      if ($urandom_range(0, 5) == 0) v[32*$urandom_range(0, 2) +: 32] = '0;
      return v;
   endfunction

   // receiver: random stalls per beat, plus an optional long hold-off
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = no_gaps ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result checker
   always @(posedge clock) begin
      vec_result_type want;
      vec_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                rsp_tuser[USER_ZERO_DIR], rsp_tuser[USER_SATURATED]};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected rsp beat: rx %h ry %h rz %h user %b",
                        got.rx, got.ry, got.rz, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
                got.zero_dir !== want.zero_dir || got.saturated !== want.saturated) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want %h %h %h z%b s%b, got %h %h %h z%b s%b",
                           want.rx, want.ry, want.rz, want.zero_dir, want.saturated,
                           got.rx, got.ry, got.rz, got.zero_dir, got.saturated);
            end
         end
      end
   end

   task automatic test_directed();
      logic [95:0] one_x;
      logic        func;
      one_x = {32'sd0, 32'sd0, QONE};
      for (int f = 0; f < 2; f++) begin
         func = (f == 0) ? FUNC_PROJ : FUNC_REJ;
         // zero direction
         send_vec(func, {QMAX, QMIN, QONE}, '0);
         // axis-aligned and parallel cases
         send_vec(func, {QONE, -QONE, 3 * QONE}, one_x);
         send_vec(func, {2 * QONE, 2 * QONE, 2 * QONE}, {QONE, QONE, QONE});
         // field extremes
         send_vec(func, {QMAX, QMAX, QMAX}, {QMAX, QMAX, QMAX});
         send_vec(func, {QMIN, QMIN, QMIN}, {QMIN, QMIN, QMIN});
         send_vec(func, {QMAX, QMIN, QMAX}, {QMIN, QMAX, QMIN});
         // saturation
         send_vec(func, {QMAX, QMAX, QMIN}, {32'sd1, 32'sd1, -32'sd1});
         send_vec(func, {QMIN, QMAX, QMAX}, {-32'sd1, 32'sd1, 32'sd1});
         // rounding cases, the second with quotients landing on one half
         send_vec(func, {32'sd0, 32'sd1, 32'sd1}, {32'sd0, 32'sd2, 32'sd0});
         send_vec(func, {32'sd0, -32'sd3, 32'sd0}, {32'sd0, 32'sd2, 32'sd2});
         send_vec(func, {32'sd0, 32'sd0, 32'sd1}, {32'sd1, 32'sd1, 32'sd0});
         // orthogonal, smallest b
         send_vec(func, {32'sd0, QONE, 32'sd0}, {32'sd0, 32'sd0, 32'sd1});
      end
   endtask

   task automatic test_random(input int count);
      logic [95:0] av;
      logic [95:0] bv;
      for (int n = 0; n < count; n++) begin
         av = rand_vec();
         bv = ($urandom_range(0, 15) == 0) ? '0 : rand_vec();
         if ($urandom_range(0, 7) == 0) av = bv;   // parallel
         send_vec(($urandom_range(0, 1) == 0) ? FUNC_PROJ : FUNC_REJ, av, bv);
      end
   endtask

   // receiver holds off while the sender keeps offering, so the pipe fills
   task automatic test_backpressure();
      no_gaps = 1;
      hold_cycles = 300;
      test_random(80);
      no_gaps = 0;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250);
      test_backpressure();
      no_gaps = 1;
      test_random(60);   // stretch with no idling
      no_gaps = 0;
      test_random(200);
      req_tvalid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> vector_projection_rejection_core.f
src/vpr_pkg.sv
src/vpr_mul_lane.sv
src/vpr_merge.sv
src/vpr_div_lane.sv
src/vector_projection_rejection_core.sv
dv/testbench.sv
